[rtl/ilcfr_pkg.sv]
// shared types and constants for the id/length/checksum frame receiver
package ilcfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [ByteW-1:0] MaxLenReset  = 8'd255;
  localparam logic [ByteW-1:0] FrameIdReset = 8'd65;

  localparam logic [CfgIdxW-1:0] RegMaxLen  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegFrameId = 8'd1;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_ACCEPT  = 3'd1,
    EV_LEN_BAD = 3'd2,
    EV_SUM_BAD = 3'd3,
    EV_ID_BAD  = 3'd4
  } event_e;

  typedef struct packed {
    logic             payload_write;
    logic [ByteW-1:0] payload_index;
    logic [ByteW-1:0] payload_byte;
    event_e           frame_event;
  } result_t;

endpackage

[rtl/ilcfr_core.sv]
// frame parser: hunt/length/body state, running sum and per-byte result
module ilcfr_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [ilcfr_pkg::ByteW-1:0]   rx_byte_i,
  input  logic [ilcfr_pkg::ByteW-1:0]   max_len_i,
  input  logic [ilcfr_pkg::ByteW-1:0]   frame_id_i,
  output ilcfr_pkg::result_t            result_o
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN,
    PH_BODY
  } phase_e;

  phase_e                        phase_q, phase_d;
  logic [ilcfr_pkg::ByteW-1:0]   count_q, count_d;
  logic [ilcfr_pkg::ByteW-1:0]   len_q, len_d;
  logic [ilcfr_pkg::ByteW-1:0]   sum_q, sum_d;
  ilcfr_pkg::result_t            res;

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    len_d   = len_q;
    sum_d   = sum_q;
    res     = '{payload_write: 1'b0, payload_index: '0, payload_byte: '0,
                frame_event: ilcfr_pkg::EV_NONE};
    unique case (phase_q)
      PH_HUNT: begin
        if (rx_byte_i == frame_id_i) begin
          phase_d = PH_LEN;
          sum_d   = '0;
        end else begin
          res.frame_event = ilcfr_pkg::EV_ID_BAD;
        end
      end
      PH_LEN: begin
        if (rx_byte_i > max_len_i) begin
          res.frame_event = ilcfr_pkg::EV_LEN_BAD;
          phase_d         = PH_HUNT;
        end else begin
          len_d   = rx_byte_i;
          count_d = '0;
          phase_d = PH_BODY;
        end
      end
      PH_BODY: begin
        if (count_q < len_q) begin
          res.payload_write = 1'b1;
          res.payload_index = count_q;
          res.payload_byte  = rx_byte_i;
          sum_d             = sum_q + rx_byte_i;
          count_d           = count_q + 8'd1;
        end else begin
          res.frame_event = (rx_byte_i == sum_q) ? ilcfr_pkg::EV_ACCEPT
                                                 : ilcfr_pkg::EV_SUM_BAD;
          sum_d           = '0;
          phase_d         = PH_HUNT;
        end
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      count_q <= '0;
      len_q   <= '0;
      sum_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
    end
  end

  assign result_o = res;

endmodule

[rtl/ilcfr_skid.sv]
// result register with a skid stage so input keeps flowing under output stall
module ilcfr_skid (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ilcfr_pkg::result_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ilcfr_pkg::result_t out_data_o
);

  logic               main_valid_q, main_valid_d;
  logic               skid_valid_q, skid_valid_d;
  ilcfr_pkg::result_t main_q, main_d;
  ilcfr_pkg::result_t skid_q, skid_d;
  logic               push;
  logic               pop;

  assign in_stall_o = skid_valid_q;
  assign push       = in_valid_i && !skid_valid_q;
  assign pop        = main_valid_q && !out_stall_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else if (push) begin
        main_d = in_data_i;
      end else begin
        main_valid_d = 1'b0;
      end
    end else if (push) begin
      if (main_valid_q) begin
        skid_d       = in_data_i;
        skid_valid_d = 1'b1;
      end else begin
        main_d       = in_data_i;
        main_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

endmodule

[rtl/id_length_checksum_frame_receiver.sv]
// top level of the id/length/checksum frame receiver
//
// rx channel: one received byte per item (rx_valid_i / rx_stall_o). the
// receiver hunts for the frame id byte, reads a length byte, issues each
// payload byte as a buffer write with its index and checks the trailing
// additive checksum. every accepted byte gives exactly one result item.
// res channel: payload_write_o, payload_index_o, payload_byte_o and
// frame_event_o under res_valid_o / res_stall_i.
// cfg channel: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// index 0 is max_payload_len, index 1 is frame_id, other indexes are
// ignored. cfg_ready_o is always high; write only while idle.
// a byte's result is registered in the result register or skid entry.
// throughput: one byte per cycle while rx_stall_o is low, set by the
// single parser step between the state registers and result register.
// stall: a result register plus one skid entry absorb output stall;
// rx_stall_o rises only once both hold results.
// reset: parser hunts for the id with a zero sum, no results pending,
// max_payload_len is 255 and frame_id is 65.
module id_length_checksum_frame_receiver (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                rx_valid_i,
  output logic                                rx_stall_o,
  input  logic [ilcfr_pkg::ByteW-1:0]         rx_byte_i,
  output logic                                res_valid_o,
  input  logic                                res_stall_i,
  output logic                                payload_write_o,
  output logic [ilcfr_pkg::ByteW-1:0]         payload_index_o,
  output logic [ilcfr_pkg::ByteW-1:0]         payload_byte_o,
  output logic [2:0]                          frame_event_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ilcfr_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [ilcfr_pkg::ByteW-1:0]         cfg_data_i
);

  logic [ilcfr_pkg::ByteW-1:0] max_len_q;
  logic [ilcfr_pkg::ByteW-1:0] frame_id_q;
  logic                        rx_accept;
  ilcfr_pkg::result_t          core_res;
  ilcfr_pkg::result_t          out_res;

  assign cfg_ready_o = 1'b1;
  assign rx_accept   = rx_valid_i && !rx_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q  <= ilcfr_pkg::MaxLenReset;
      frame_id_q <= ilcfr_pkg::FrameIdReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ilcfr_pkg::RegMaxLen:  max_len_q  <= cfg_data_i;
        ilcfr_pkg::RegFrameId: frame_id_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  ilcfr_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (rx_accept),
    .rx_byte_i  (rx_byte_i),
    .max_len_i  (max_len_q),
    .frame_id_i (frame_id_q),
    .result_o   (core_res)
  );

  ilcfr_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rx_valid_i),
    .in_stall_o  (rx_stall_o),
    .in_data_i   (core_res),
    .out_valid_o (res_valid_o),
    .out_stall_i (res_stall_i),
    .out_data_o  (out_res)
  );

  assign payload_write_o = out_res.payload_write;
  assign payload_index_o = out_res.payload_index;
  assign payload_byte_o  = out_res.payload_byte;
  assign frame_event_o   = out_res.frame_event;

endmodule

[rtl/ilcfr_checker.sv]
// port-level checks for the frame receiver, bound to the top level
module ilcfr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          rx_valid_i,
  input logic                          rx_stall_o,
  input logic [ilcfr_pkg::ByteW-1:0]   rx_byte_i,
  input logic                          res_valid_o,
  input logic                          res_stall_i,
  input logic                          payload_write_o,
  input logic [ilcfr_pkg::ByteW-1:0]   payload_index_o,
  input logic [ilcfr_pkg::ByteW-1:0]   payload_byte_o,
  input logic [2:0]                    frame_event_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [ilcfr_pkg::CfgIdxW-1:0] cfg_index_i,
  input logic [ilcfr_pkg::ByteW-1:0]   cfg_data_i
);

  // stalled item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o && $stable(payload_write_o)
      && $stable(payload_index_o) && $stable(payload_byte_o) && $stable(frame_event_o))
    else $error("stalled result item changed");

  // input stall only while a result is pending in the main slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_stall_o |-> res_valid_o)
    else $error("input stalled with no result pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && payload_write_o |-> frame_event_o == ilcfr_pkg::EV_NONE)
    else $error("payload write carries a frame event");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !payload_write_o |-> payload_index_o == '0 && payload_byte_o == '0)
    else $error("non-payload item carries payload data");

  // with no result pending an accepted byte shows its result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_valid_i && !rx_stall_o && !res_valid_o |=> res_valid_o)
    else $error("accepted item produced no result");

endmodule

bind id_length_checksum_frame_receiver ilcfr_checker u_ilcfr_checker (.*);

[tb/tb_id_length_checksum_frame_receiver.sv]
// testbench for the id/length/checksum frame receiver with a self-checking byte predictor
`timescale 1ns / 1ps

module tb_id_length_checksum_frame_receiver;

  typedef logic [ilcfr_pkg::ByteW-1:0] octet_t;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomItems = 1230;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic rx_valid = 1'b0;
  octet_t rx_byte = '0;
  logic res_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [ilcfr_pkg::CfgIdxW-1:0] cfg_index = '0;
  octet_t cfg_data = '0;

  logic rx_stall_o;
  logic res_valid_o;
  logic payload_write_o;
  octet_t payload_index_o;
  octet_t payload_byte_o;
  logic [2:0] frame_event_o;
  logic cfg_ready_o;

  // predictor state and register copies
  octet_t cfg_max_len = ilcfr_pkg::MaxLenReset;
  octet_t cfg_frame_id = ilcfr_pkg::FrameIdReset;
  logic [8:0] hunt_pos = '0;
  octet_t frame_len = '0;
  octet_t frame_sum = '0;

  ilcfr_pkg::result_t expected_results[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;

  id_length_checksum_frame_receiver u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .rx_valid_i     (rx_valid),
    .rx_stall_o     (rx_stall_o),
    .rx_byte_i      (rx_byte),
    .res_valid_o    (res_valid_o),
    .res_stall_i    (res_stall),
    .payload_write_o(payload_write_o),
    .payload_index_o(payload_index_o),
    .payload_byte_o (payload_byte_o),
    .frame_event_o  (frame_event_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("id_length_checksum_frame_receiver test failed");
      $finish;
    end
  end

  function automatic void deframe_byte(input octet_t b);
    ilcfr_pkg::result_t r;
    logic [8:0] k;
    r = '{payload_write: 1'b0, payload_index: '0, payload_byte: '0,
          frame_event: ilcfr_pkg::EV_NONE};
    if (hunt_pos == 9'd0) begin
      if (b == cfg_frame_id) begin
        hunt_pos = 9'd1;
        frame_sum = '0;
      end else begin
        r.frame_event = ilcfr_pkg::EV_ID_BAD;
      end
    end else if (hunt_pos == 9'd1) begin
      if (b > cfg_max_len) begin
        r.frame_event = ilcfr_pkg::EV_LEN_BAD;
        hunt_pos = 9'd0;
      end else begin
        frame_len = b;
        hunt_pos = 9'd2;
      end
    end else begin
      k = hunt_pos - 9'd2;
      if (k < frame_len) begin
        r.payload_write = 1'b1;
        r.payload_index = k[ilcfr_pkg::ByteW-1:0];
        r.payload_byte = b;
        frame_sum = frame_sum + b;
        hunt_pos = hunt_pos + 9'd1;
      end else if (k == frame_len) begin
        r.frame_event = (b == frame_sum) ? ilcfr_pkg::EV_ACCEPT : ilcfr_pkg::EV_SUM_BAD;
        hunt_pos = 9'd0;
        frame_sum = '0;
      end else begin
        hunt_pos = 9'd0;
      end
    end
    expected_results.push_back(r);
  endfunction

  // result side: random stall and in-order compare
  always @(posedge clk) begin
    ilcfr_pkg::result_t want;
    res_stall <= ($urandom_range(99) < rcv_stall_pct);
    if (rst_n && res_valid_o && !res_stall) begin
      if (expected_results.size() == 0) begin
        $error("result item with no byte pending");
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (payload_write_o !== want.payload_write) begin
          $error("payload_write: expected %0d, actual %0d", want.payload_write,
                 payload_write_o);
          errors++;
        end
        if (payload_index_o !== want.payload_index) begin
          $error("payload_index: expected %0d, actual %0d", want.payload_index,
                 payload_index_o);
          errors++;
        end
        if (payload_byte_o !== want.payload_byte) begin
          $error("payload_byte: expected %0d, actual %0d", want.payload_byte,
                 payload_byte_o);
          errors++;
        end
        if (frame_event_o !== want.frame_event) begin
          $error("frame_event: expected %0d, actual %0d", want.frame_event, frame_event_o);
          errors++;
        end
      end
    end
  end

  task automatic send_byte(input octet_t b);
    while ($urandom_range(99) < snd_idle_pct) begin
      rx_valid <= 1'b0;
      @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (rx_stall_o);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_idle();
    rx_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ilcfr_pkg::CfgIdxW-1:0] idx, input octet_t data,
                           input bit hold);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready_o);
    if (!hold) cfg_valid <= 1'b0;
    case (idx)
      ilcfr_pkg::RegMaxLen: cfg_max_len = data;
      ilcfr_pkg::RegFrameId: cfg_frame_id = data;
      default: ;
    endcase
  endtask

  task automatic configure(input octet_t max_len, input octet_t id);
    wait_idle();
    write_reg(ilcfr_pkg::RegMaxLen, max_len, 1'b1);
    write_reg(ilcfr_pkg::RegFrameId, id, 1'b0);
  endtask

  task automatic send_frame(input octet_t len, input bit good_sum, input int stop_at);
    octet_t sum;
    sum = '0;
    send_byte(cfg_frame_id);
    send_byte(len);
    if (len > cfg_max_len) return;
    for (int i = 0; i < len; i++) begin
      octet_t b;
      if (i == stop_at) return;
      b = octet_t'($urandom_range(255));
      sum = sum + b;
      send_byte(b);
    end
    if (stop_at >= 0 && stop_at == len) return;
    send_byte(good_sum ? sum : octet_t'($urandom_range(255)));
  endtask

  task automatic test_directed();
    send_byte(8'h00);
    send_byte(8'hff);
    send_frame(8'd0, 1'b1, -1);
    send_byte(cfg_frame_id);
    send_byte(8'd3);
    send_byte(8'hff);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(cfg_frame_id);
    send_byte(8'd1);
    send_byte(8'h55);
    send_byte(8'h54);
    configure(8'd2, ilcfr_pkg::FrameIdReset);
    send_frame(8'd3, 1'b1, -1);
    send_frame(8'd2, 1'b1, -1);
  endtask

  task automatic test_config_extremes();
    configure(8'd0, 8'd0);
    send_byte(8'hff);
    send_frame(8'd1, 1'b1, -1);
    send_frame(8'd0, 1'b1, -1);
    configure(8'd255, 8'd255);
    send_byte(8'd255);
    send_byte(8'd0);
    send_byte(8'd1);
    // stray register index must not touch either register
    wait_idle();
    write_reg(ilcfr_pkg::CfgIdxW'($urandom_range(255, ilcfr_pkg::RegFrameId + 1)),
              octet_t'($urandom_range(255)), 1'b0);
    send_frame(8'd255, 1'b1, -1);
  endtask

  task automatic test_random(input int unsigned goal);
    int unsigned stop_count;
    octet_t len;
    octet_t new_max;
    octet_t new_id;
    int r;
    stop_count = bytes_sent + goal;
    while (bytes_sent < stop_count) begin
      if ($urandom_range(99) < 4) begin
        case ($urandom_range(3))
          0: new_max = 8'd0;
          1: new_max = 8'd255;
          default: new_max = octet_t'($urandom_range(1, 254));
        endcase
        case ($urandom_range(3))
          0: new_id = 8'd0;
          1: new_id = 8'd255;
          default: new_id = octet_t'($urandom_range(255));
        endcase
        configure(new_max, new_id);
      end
      if ($urandom_range(99) < 2) wait_idle();
      r = $urandom_range(99);
      if ($urandom_range(99) < 4) len = octet_t'($urandom_range(255));
      else len = octet_t'($urandom_range(0, (cfg_max_len < 12) ? cfg_max_len : 12));
      if (r < 10) send_byte(octet_t'($urandom_range(255)));
      else if (r < 16) send_frame(len, 1'b1, $urandom_range(0, len));
      else send_frame(len, $urandom_range(99) < 75, -1);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    snd_idle_pct = 19;
    rcv_stall_pct = 45;
    test_random(RandomItems / 3);
    wait_idle();
    snd_idle_pct = 45;
    rcv_stall_pct = 19;
    test_random(RandomItems / 3);
    wait_idle();
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    test_random(RandomItems / 3);
    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("id_length_checksum_frame_receiver test passed");
    end else begin
      $display("id_length_checksum_frame_receiver test failed");
    end
    $finish;
  end

endmodule
